>>> src/bmrc_pkg.sv
// ----------------------------------------------------------------------------
// bmrc_pkg
// Shared types, sizes and helpers for the binary matrix rank counter.
// ----------------------------------------------------------------------------
package bmrc_pkg;

  // matrix geometry and counter size
  localparam int unsigned MATRIX_SIZE = 32;
  localparam int unsigned COUNT_WIDTH = 32;

  // fixed field widths of the channels
  localparam int unsigned ROW_W      = 32;
  localparam int unsigned RANK_OUT_W = 6;
  localparam int unsigned TOTAL_W    = 32;

  // derived widths
  localparam int unsigned BIT_W     = $clog2(MATRIX_SIZE);
  localparam int unsigned ROW_POS_W = $clog2(MATRIX_SIZE);
  localparam int unsigned RANK_W    = $clog2(MATRIX_SIZE + 1);

  // item opcodes
  localparam logic OP_ROW   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } bmrc_state_e;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // saturating increment of a counter
  function automatic count_t sat_inc(input count_t c);
    count_t res;
    res = c;
    if (c != '1) begin
      res = c + count_t'(1);
    end
    return res;
  endfunction

endpackage

>>> src/bmrc_if.sv
// ----------------------------------------------------------------------------
// bmrc_in_if / bmrc_out_if
// Valid/ready channels carrying row items in and rank results out.
// ----------------------------------------------------------------------------
interface bmrc_in_if import bmrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [ROW_W-1:0] row_bits;

  modport source (output valid, output op, output row_bits, input ready);
  modport sink   (input valid, input op, input row_bits, output ready);
endinterface

interface bmrc_out_if import bmrc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [RANK_OUT_W-1:0] matrix_rank;
  logic [TOTAL_W-1:0]    full_rank_total;
  logic [TOTAL_W-1:0]    near_full_total;
  logic [TOTAL_W-1:0]    matrices_total;

  modport source (output valid, output matrix_rank, output full_rank_total,
                  output near_full_total, output matrices_total, input ready);
  modport sink   (input valid, input matrix_rank, input full_rank_total,
                  input near_full_total, input matrices_total, output ready);
endinterface

>>> src/binary_matrix_rank_counter_top.sv
// ----------------------------------------------------------------------------
// binary_matrix_rank_counter_top
// GF(2) rank of 32x32 bit matrices with saturating rank statistics.
// ----------------------------------------------------------------------------
// Each row item is reduced against a basis held by pivot position, highest
// bit first, one pivot bit per cycle through a single conditional XOR unit
// fed by a basis memory with one write and one read port that is read one
// bit ahead. A row is accepted in the idle state and then scanned from the top
// bit down; the scan stops early once the row is inserted as a new pivot or
// reduces to zero. The row that completes a matrix leads to a finish state
// that updates the counts and loads the result register once it is free; the
// result may then wait for the sink while the next rows come in. A clear item
// is taken in the idle state and gives no result. The block is not ready while
// a row is being scanned or a finished matrix waits for the result register.
// ----------------------------------------------------------------------------
module binary_matrix_rank_counter_top import bmrc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  bmrc_in_if.sink           in_i,
  bmrc_out_if.source        out_o
);

  localparam logic [BIT_W-1:0]     TopBit  = BIT_W'(MATRIX_SIZE - 1);
  localparam logic [ROW_POS_W-1:0] LastRow = ROW_POS_W'(MATRIX_SIZE - 1);
  localparam logic [RANK_W-1:0]    FullRk  = RANK_W'(MATRIX_SIZE);
  localparam logic [RANK_W-1:0]    NearRk  = RANK_W'(MATRIX_SIZE - 1);

  bmrc_state_e state_q, state_d;

  // basis storage, one row per pivot bit
  logic [MATRIX_SIZE-1:0] basis_mem [MATRIX_SIZE];
  logic [MATRIX_SIZE-1:0] rd_q;
  logic [BIT_W-1:0]       rd_addr;
  logic                   mem_we;

  logic [MATRIX_SIZE-1:0] basis_valid_q, basis_valid_d;
  logic [MATRIX_SIZE-1:0] work_q, work_d;
  logic [BIT_W-1:0]       bit_q, bit_d;
  logic [ROW_POS_W-1:0]   row_pos_q, row_pos_d;
  logic [RANK_W-1:0]      rank_q, rank_d;
  count_t                 full_cnt_q, full_cnt_d;
  count_t                 near_cnt_q, near_cnt_d;
  count_t                 mat_cnt_q, mat_cnt_d;

  logic                   out_valid_q, out_valid_d;
  logic                   out_load;
  logic [RANK_OUT_W-1:0]  out_rank_q;
  logic [TOTAL_W-1:0]     out_full_q, out_near_q, out_mat_q;

  logic                   pivot;
  logic                   done;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer and reduction step
  always_comb begin
    state_d       = state_q;
    basis_valid_d = basis_valid_q;
    work_d        = work_q;
    bit_d         = bit_q - 1'b1;
    rd_addr       = bit_q - 1'b1;
    row_pos_d     = row_pos_q;
    rank_d        = rank_q;
    full_cnt_d    = full_cnt_q;
    near_cnt_d    = near_cnt_q;
    mat_cnt_d     = mat_cnt_q;
    mem_we        = 1'b0;
    out_load      = 1'b0;
    in_i.ready    = 1'b0;
    pivot         = work_q[bit_q];
    done          = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        rd_addr    = TopBit;
        if (in_i.valid) begin
          if (in_i.op == OP_CLEAR) begin
            basis_valid_d = '0;
            row_pos_d     = '0;
            rank_d        = '0;
            full_cnt_d    = '0;
            near_cnt_d    = '0;
            mat_cnt_d     = '0;
          end else begin
            work_d  = MATRIX_SIZE'(in_i.row_bits);
            bit_d   = TopBit;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // one pivot bit per cycle: eliminate or insert
        if (pivot) begin
          if (basis_valid_q[bit_q]) begin
            work_d = work_q ^ rd_q;
          end else begin
            mem_we               = 1'b1;
            basis_valid_d[bit_q] = 1'b1;
            rank_d               = rank_q + 1'b1;
            done                 = 1'b1;
          end
        end
        if (bit_q == '0 || work_d == '0) begin
          done = 1'b1;
        end
        if (done) begin
          if (row_pos_q == LastRow) begin
            state_d = ST_FINISH;
          end else begin
            row_pos_d = row_pos_q + 1'b1;
            state_d   = ST_IDLE;
          end
        end
      end

      ST_FINISH: begin
        // matrix complete: update counts once the result slot is free
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          if (rank_q == FullRk) begin
            full_cnt_d = sat_inc(full_cnt_q);
          end else if (rank_q == NearRk) begin
            near_cnt_d = sat_inc(near_cnt_q);
          end
          mat_cnt_d     = sat_inc(mat_cnt_q);
          basis_valid_d = '0;
          row_pos_d     = '0;
          rank_d        = '0;
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // basis memory, registered read one bit ahead of the scan
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      basis_mem[bit_q] <= work_q;
    end
    rd_q <= basis_mem[rd_addr];
  end

  // working row and bit pointer
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    bit_q  <= bit_d;
  end

  // matrix progress and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basis_valid_q <= '0;
      row_pos_q     <= '0;
      rank_q        <= '0;
      full_cnt_q    <= '0;
      near_cnt_q    <= '0;
      mat_cnt_q     <= '0;
    end else begin
      basis_valid_q <= basis_valid_d;
      row_pos_q     <= row_pos_d;
      rank_q        <= rank_d;
      full_cnt_q    <= full_cnt_d;
      near_cnt_q    <= near_cnt_d;
      mat_cnt_q     <= mat_cnt_d;
    end
  end

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rank_q <= RANK_OUT_W'(rank_q);
      out_full_q <= TOTAL_W'(full_cnt_d);
      out_near_q <= TOTAL_W'(near_cnt_d);
      out_mat_q  <= TOTAL_W'(mat_cnt_d);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.matrix_rank     = out_rank_q;
  assign out_o.full_rank_total = out_full_q;
  assign out_o.near_full_total = out_near_q;
  assign out_o.matrices_total  = out_mat_q;

endmodule

>>> src/bmrc_checker.sv
// ----------------------------------------------------------------------------
// bmrc_checker
// Port-level checks on the rank counter, bound to the top level.
// ----------------------------------------------------------------------------
module bmrc_checker import bmrc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  in_op_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [RANK_OUT_W-1:0] out_rank_i,
  input logic [TOTAL_W-1:0]    out_full_i,
  input logic [TOTAL_W-1:0]    out_near_i,
  input logic [TOTAL_W-1:0]    out_mat_i
);

  // a waiting result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  // a waiting result holds its rank and matrix total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_rank_i) && $stable(out_mat_i))
    else $error("result item changed while stalled");

  // a row item keeps the block busy for its scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == OP_ROW |=> !in_ready_i)
    else $error("row item accepted without a scan");

  // rank never exceeds the matrix size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (MATRIX_SIZE > 63) || (out_rank_i <= RANK_OUT_W'(MATRIX_SIZE)))
    else $error("rank beyond matrix size");

  // class totals stay within the matrix total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_full_i <= out_mat_i) && (out_near_i <= out_mat_i))
    else $error("class total above matrix total");

endmodule

bind binary_matrix_rank_counter_top bmrc_checker u_bmrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.op),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_rank_i  (out_o.matrix_rank),
  .out_full_i  (out_o.full_rank_total),
  .out_near_i  (out_o.near_full_total),
  .out_mat_i   (out_o.matrices_total)
);

>>> sim/rank_stats_checker.sv
// ----------------------------------------------------------------------------
// rank_stats_checker
// Watches the row and report channels of the rank counter, keeps its own
// GF(2) pivot basis and saturating totals, and checks every report in order.
// ----------------------------------------------------------------------------
module rank_stats_checker import bmrc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  bmrc_in_if   row_mon_i,
  bmrc_out_if  report_mon_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   matrices_o,
  output int   full_rank_o,
  output int   near_full_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [RANK_OUT_W-1:0] rank;
    logic [TOTAL_W-1:0]    full_total;
    logic [TOTAL_W-1:0]    near_total;
    logic [TOTAL_W-1:0]    all_total;
  } rank_report_t;

  // basis by pivot bit, current matrix progress and running totals
  logic [MATRIX_SIZE-1:0] pivot_row [MATRIX_SIZE];
  logic [MATRIX_SIZE-1:0] pivot_used;
  int unsigned            rows_in_matrix;
  count_t                 full_rank_cnt;
  count_t                 near_full_cnt;
  count_t                 matrix_cnt;
  rank_report_t           awaited_reports [$];

  // flag one report field that differs
  function automatic void flag_field(input string name, input logic [TOTAL_W-1:0] want,
                                     input logic [TOTAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict
    logic [MATRIX_SIZE-1:0] residue;
    logic                   placed;
    int unsigned            rank_now;
    rank_report_t           want;
    if (!rst_ni) begin
      pivot_used     = '0;
      rows_in_matrix = 0;
      full_rank_cnt  = '0;
      near_full_cnt  = '0;
      matrix_cnt     = '0;
      awaited_reports.delete();
      fail_count_o   = 0;
      matrices_o     = 0;
      full_rank_o    = 0;
      near_full_o    = 0;
      pending_o     <= 0;
    end else begin
      // item taken by the block
      if (row_mon_i.valid && row_mon_i.ready) begin
        if (row_mon_i.op == OP_CLEAR) begin
          pivot_used     = '0;
          rows_in_matrix = 0;
          full_rank_cnt  = '0;
          near_full_cnt  = '0;
          matrix_cnt     = '0;
        end else begin
          // reduce the row against the basis, highest pivot first
          residue = MATRIX_SIZE'(row_mon_i.row_bits);
          placed  = 1'b0;
          for (int b = MATRIX_SIZE - 1; b >= 0; b--) begin
            if (!placed && residue[b]) begin
              if (pivot_used[b]) begin
                residue = residue ^ pivot_row[b];
              end else begin
                pivot_row[b]  = residue;
                pivot_used[b] = 1'b1;
                placed        = 1'b1;
              end
            end
          end
          rows_in_matrix++;
          // last row of a matrix: bump the totals and queue the report
          if (rows_in_matrix == MATRIX_SIZE) begin
            rank_now = $countones(pivot_used);
            if (rank_now == MATRIX_SIZE) begin
              if (full_rank_cnt != '1) full_rank_cnt++;
              full_rank_o++;
            end else if (rank_now == MATRIX_SIZE - 1) begin
              if (near_full_cnt != '1) near_full_cnt++;
              near_full_o++;
            end
            if (matrix_cnt != '1) matrix_cnt++;
            want.rank       = RANK_OUT_W'(rank_now);
            want.full_total = TOTAL_W'(full_rank_cnt);
            want.near_total = TOTAL_W'(near_full_cnt);
            want.all_total  = TOTAL_W'(matrix_cnt);
            awaited_reports.push_back(want);
            matrices_o++;
            pivot_used     = '0;
            rows_in_matrix = 0;
          end
        end
      end
      // report taken from the block
      if (report_mon_i.valid && report_mon_i.ready) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t: report with none expected, actual rank %0d totals %0d %0d %0d",
                   $time, report_mon_i.matrix_rank, report_mon_i.full_rank_total,
                   report_mon_i.near_full_total, report_mon_i.matrices_total);
          fail_count_o++;
        end else begin
          want = awaited_reports.pop_front();
          flag_field("matrix_rank", want.rank, report_mon_i.matrix_rank);
          flag_field("full_rank_total", want.full_total, report_mon_i.full_rank_total);
          flag_field("near_full_total", want.near_total, report_mon_i.near_full_total);
          flag_field("matrices_total", want.all_total, report_mon_i.matrices_total);
        end
      end
      pending_o <= awaited_reports.size();
    end
  end

endmodule

>>> sim/binary_matrix_rank_counter_top_test.sv
// ----------------------------------------------------------------------------
// binary_matrix_rank_counter_top_test
// Feeds row and clear items into the rank counter: a few edge rows first,
// then whole matrices of chosen rank structure with stray clears, under
// random idling on both channels and one long report stall. A checker
// beside the block predicts and compares every report.
// ----------------------------------------------------------------------------
module binary_matrix_rank_counter_top_test;
  import bmrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 4;
  localparam int ITEM_TARGET   = 1100;
  localparam int IDLE_PCT      = 26;
  localparam int HOLD_CYCLES   = 2500;
  localparam int TAIL_CYCLES   = 64;
  localparam int CYCLE_LIMIT   = 400000;

  typedef enum int {
    MX_RANDOM,
    MX_TRIANGULAR,
    MX_ONE_SHORT,
    MX_LOW_RANK,
    MX_SPARSE,
    MX_UNIFORM
  } matrix_kind_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   cycle_count = 0;
  int   items_sent  = 0;
  int   clears_sent = 0;

  int   fail_count;
  int   pending_reports;
  int   matrices_checked;
  int   full_rank_seen;
  int   near_full_seen;

  bmrc_in_if  row_ch ();
  bmrc_out_if report_ch ();

  binary_matrix_rank_counter_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (row_ch),
    .out_o  (report_ch)
  );

  rank_stats_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .row_mon_i    (row_ch),
    .report_mon_i (report_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_reports),
    .matrices_o   (matrices_checked),
    .full_rank_o  (full_rank_seen),
    .near_full_o  (near_full_seen)
  );

  // clock and cycle count
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // give up if the run hangs
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d reports outstanding", cycle_count, pending_reports);
    $display("binary_matrix_rank_counter_top test failed");
    $finish;
  end

  // offer one item, idling at random first, and wait until it is taken
  task automatic send_item(input logic op, input logic [ROW_W-1:0] bits);
    logic burst;
    burst = (items_sent >= 300) && (items_sent < 600);
    while (!burst && $urandom_range(0, 99) < IDLE_PCT) begin
      row_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    row_ch.valid    <= 1'b1;
    row_ch.op       <= op;
    row_ch.row_bits <= bits;
    @(posedge clk_i);
    while (!row_ch.ready) @(posedge clk_i);
    items_sent++;
    if (op == OP_CLEAR) clears_sent++;
  endtask

  // report sink: random stalls, one long hold-off, and a stretch of none
  initial begin : report_sink
    int  taken;
    logic held;
    taken = 0;
    held  = 1'b0;
    report_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (report_ch.valid && report_ch.ready) taken++;
      if (!held && taken >= 3) begin
        held = 1'b1;
        report_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        report_ch.ready <= ((cycle_count >= 6000) && (cycle_count < 14000)) ||
                           ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [ROW_W-1:0] mat_rows [MATRIX_SIZE];
    logic [ROW_W-1:0] gen_vec  [MATRIX_SIZE];
    logic [ROW_W-1:0] tmp_row;
    matrix_kind_e     kind;
    int               matrix_idx;
    int               pattern;
    int               gen_count;
    int               pick;
    int               src_a;
    int               src_b;
    int               swap_idx;
    int               noise_at;

    row_ch.valid    <= 1'b0;
    row_ch.op       <= OP_ROW;
    row_ch.row_bits <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edge rows and clears, including a clear that drops a partial matrix
    send_item(OP_CLEAR, '0);
    send_item(OP_CLEAR, '1);
    send_item(OP_ROW, '0);
    send_item(OP_ROW, '1);
    send_item(OP_ROW, ROW_W'(1));
    send_item(OP_ROW, ROW_W'(1) << (ROW_W - 1));
    send_item(OP_ROW, 32'hAAAA_AAAA);
    send_item(OP_ROW, 32'h5555_5555);
    send_item(OP_ROW, 32'hAAAA_AAAA);
    send_item(OP_CLEAR, $urandom());
    for (int r = 0; r < 8; r++) begin
      send_item(OP_ROW, ROW_W'(1) << $urandom_range(0, ROW_W - 1));
    end
    send_item(OP_CLEAR, '0);

    // whole matrices of chosen structure, with stray clears now and then
    matrix_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      kind = (matrix_idx < 3) ? MX_UNIFORM : matrix_kind_e'($urandom_range(0, 5));
      case (kind)
        MX_RANDOM: begin
          foreach (mat_rows[r]) mat_rows[r] = $urandom();
        end
        MX_TRIANGULAR, MX_ONE_SHORT: begin
          // one row per pivot, random bits below it
          foreach (mat_rows[r]) begin
            mat_rows[r] = (ROW_W'(1) << r) | ($urandom() & ((ROW_W'(1) << r) - 1));
          end
          // replace one row by the sum of two others: rank one below full
          if (kind == MX_ONE_SHORT) begin
            pick  = $urandom_range(0, MATRIX_SIZE - 1);
            src_a = (pick + 1 + $urandom_range(0, MATRIX_SIZE - 2)) % MATRIX_SIZE;
            src_b = pick;
            while (src_b == pick || src_b == src_a) src_b = $urandom_range(0, MATRIX_SIZE - 1);
            mat_rows[pick] = mat_rows[src_a] ^ mat_rows[src_b];
          end
        end
        MX_LOW_RANK: begin
          // rows drawn from the span of up to MATRIX_SIZE random generators
          gen_count = $urandom_range(0, MATRIX_SIZE);
          foreach (gen_vec[g]) gen_vec[g] = $urandom();
          foreach (mat_rows[r]) begin
            tmp_row = '0;
            for (int g = 0; g < gen_count; g++) begin
              if ($urandom_range(0, 1) == 1) tmp_row = tmp_row ^ gen_vec[g];
            end
            mat_rows[r] = tmp_row;
          end
        end
        MX_SPARSE: begin
          foreach (mat_rows[r]) begin
            case ($urandom_range(0, 2))
              0: mat_rows[r] = '0;
              1: mat_rows[r] = ROW_W'(1) << $urandom_range(0, ROW_W - 1);
              default: mat_rows[r] = (ROW_W'(1) << $urandom_range(0, ROW_W - 1)) |
                                     (ROW_W'(1) << $urandom_range(0, ROW_W - 1));
            endcase
          end
        end
        default: begin
          // identity, all zero or all ones
          pattern = (matrix_idx < 3) ? matrix_idx : $urandom_range(0, 2);
          foreach (mat_rows[r]) begin
            case (pattern)
              0: mat_rows[r] = ROW_W'(1) << r;
              1: mat_rows[r] = '0;
              default: mat_rows[r] = '1;
            endcase
          end
        end
      endcase

      // shuffle the row order
      for (int r = MATRIX_SIZE - 1; r > 0; r--) begin
        swap_idx           = $urandom_range(0, r);
        tmp_row            = mat_rows[r];
        mat_rows[r]        = mat_rows[swap_idx];
        mat_rows[swap_idx] = tmp_row;
      end

      noise_at = ($urandom_range(0, 24) == 0) ? $urandom_range(0, MATRIX_SIZE - 1) : -1;
      for (int r = 0; r < MATRIX_SIZE; r++) begin
        if (r == noise_at) send_item(OP_CLEAR, $urandom());
        send_item(OP_ROW, mat_rows[r]);
      end
      if ($urandom_range(0, 19) == 0) send_item(OP_CLEAR, $urandom());
      matrix_idx++;
    end
    row_ch.valid <= 1'b0;

    // drain the reports, then let the block settle
    @(negedge clk_i);
    while (pending_reports != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d row items and %0d clear items, %0d matrices reported",
             items_sent - clears_sent, clears_sent, matrices_checked);
    $display("of those %0d full rank and %0d one below full; sink held off %0d cycles once",
             full_rank_seen, near_full_seen, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("binary_matrix_rank_counter_top test passed");
    end else begin
      $display("binary_matrix_rank_counter_top test failed");
    end
    $finish;
  end

endmodule
